[rtl/vzc_pkg.sv]
// Shared types, register indexes, command codes and constants for the
// vibration zero-crossing frequency estimator. No dependencies.
package vzc_pkg;

  // Field and port widths
  localparam int ACC_W        = 16;
  localparam int IN_TDATA_W   = 48;
  localparam int HZ_W         = 17;
  localparam int COUNT_W      = 16;
  localparam int OUT_TDATA_W  = 40;
  localparam int DUR_W        = 16;
  localparam int RATE_W       = 10;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DURATION = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE     = 1'd1;

  // Register reset values
  localparam logic [DUR_W-1:0]  DURATION_RESET = 16'd1000;
  localparam logic [RATE_W-1:0] RATE_RESET     = 10'd200;
  localparam logic [RATE_W-1:0] MIN_RATE       = 10'd20;

  // Default fixed-point formats
  localparam int HP_FRAC_BITS_DEF    = 8;
  localparam int ALPHA_FRAC_BITS_DEF = 15;

  // Arithmetic constants
  localparam int G_SHIFT      = 14;     // 16384 counts per g
  localparam int ALPHA_NUM    = 95;     // coefficient 0.95 = 95/100
  localparam int ALPHA_DEN    = 100;
  localparam int MS_PER_S     = 1000;
  localparam int HZ_SCALE     = 256000; // 2 * 1000 ms * 128 (Q8, halved below)
  localparam int LIMIT_SHIFT  = 7;      // rate/2 in Q8 is rate * 128

  // Sequencer step counts
  localparam int STEP_W     = 5;
  localparam int MAC_STEPS  = 3;
  localparam int ROOT_STEPS = 16;
  localparam int DIV_STEPS  = 18;
  localparam int NUM_W      = 34;
  localparam int DEN_W      = 17;

  // Datapath operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_MAC    = 4'd2;
  localparam logic [OP_W-1:0] OP_ROOT   = 4'd3;
  localparam logic [OP_W-1:0] OP_DIFF   = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd5;
  localparam logic [OP_W-1:0] OP_UPDATE = 4'd6;
  localparam logic [OP_W-1:0] OP_DIVSET = 4'd7;
  localparam logic [OP_W-1:0] OP_DIVCHK = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd10;

  // Controller to datapath
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic window_done;
    logic out_free;
  } status_t;

endpackage

[rtl/vzc_ctrl.sv]
// Sequencer for the estimator: walks each item through square, root,
// filter, window check and, at window end, the divider. Uses vzc_pkg.
module vzc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  vzc_pkg::status_t status,
  output vzc_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAC    = 4'd1;
  localparam logic [3:0] S_ROOT   = 4'd2;
  localparam logic [3:0] S_DIFF   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_UPDATE = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_DIVSET = 4'd7;
  localparam logic [3:0] S_DIVCHK = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  localparam logic [vzc_pkg::STEP_W-1:0] MAC_LAST  =
    vzc_pkg::STEP_W'(vzc_pkg::MAC_STEPS - 1);
  localparam logic [vzc_pkg::STEP_W-1:0] ROOT_LAST =
    vzc_pkg::STEP_W'(vzc_pkg::ROOT_STEPS - 1);
  localparam logic [vzc_pkg::STEP_W-1:0] DIV_LAST  =
    vzc_pkg::STEP_W'(vzc_pkg::DIV_STEPS - 1);

  logic [3:0]                   state, state_next;
  logic [vzc_pkg::STEP_W-1:0]   step, step_next;

  // Next state, step counter and datapath command
  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd.op        = vzc_pkg::OP_IDLE;
    cmd.step      = step;
    s_axis_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.op     = vzc_pkg::OP_LOAD;
          state_next = S_MAC;
          step_next  = '0;
        end
      end
      S_MAC: begin
        cmd.op = vzc_pkg::OP_MAC;
        if (step == MAC_LAST) begin
          step_next  = '0;
          state_next = S_ROOT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.op = vzc_pkg::OP_ROOT;
        if (step == ROOT_LAST) begin
          step_next  = '0;
          state_next = S_DIFF;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DIFF: begin
        cmd.op     = vzc_pkg::OP_DIFF;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = vzc_pkg::OP_MUL;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.op     = vzc_pkg::OP_UPDATE;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.window_done ? S_DIVSET : S_IDLE;
      end
      S_DIVSET: begin
        cmd.op     = vzc_pkg::OP_DIVSET;
        state_next = S_DIVCHK;
      end
      S_DIVCHK: begin
        cmd.op     = vzc_pkg::OP_DIVCHK;
        step_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = vzc_pkg::OP_DIV;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = S_EMIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_EMIT: begin
        // Hold here until the output register can take the result.
        if (status.out_free) begin
          cmd.op     = vzc_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

[rtl/vzc_datapath.sv]
// Datapath of the estimator: configuration registers, shared square unit,
// bit-pair square root, high-pass filter, window state, divider and the
// output register. Driven by vzc_ctrl commands; uses vzc_pkg.
module vzc_datapath #(
  parameter int HP_FRAC_BITS    = vzc_pkg::HP_FRAC_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = vzc_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [vzc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                cfg_we,
  input  logic [vzc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [vzc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vzc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,
  input  vzc_pkg::cmd_t                       cmd,
  output vzc_pkg::status_t                    status
);

  localparam int AW  = vzc_pkg::ACC_W;
  localparam int DW  = 18 + HP_FRAC_BITS;
  localparam int SW  = ((DW > 32) ? DW : 32) + 1;
  localparam int PW  = SW + ALPHA_FRAC_BITS + 2;
  localparam int QW  = vzc_pkg::DIV_STEPS;
  localparam int NW  = vzc_pkg::NUM_W;
  localparam int EW  = vzc_pkg::DEN_W;
  localparam int HW  = vzc_pkg::HZ_W;
  localparam int CW  = vzc_pkg::COUNT_W;
  localparam int RW  = vzc_pkg::RATE_W;
  localparam int PRW = vzc_pkg::DUR_W + vzc_pkg::RATE_W;

  localparam int ALPHA_Q =
    ((vzc_pkg::ALPHA_NUM << ALPHA_FRAC_BITS) + vzc_pkg::ALPHA_DEN / 2) / vzc_pkg::ALPHA_DEN;
  localparam logic signed [ALPHA_FRAC_BITS+1:0] ALPHA_S = (ALPHA_FRAC_BITS + 2)'(ALPHA_Q);
  localparam logic signed [DW-1:0] RND_D = DW'(1) <<< (vzc_pkg::G_SHIFT - 1);
  localparam logic signed [PW-1:0] RND_A = {{(PW-1){1'b0}}, 1'b1} <<< (ALPHA_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HP_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PW-1:0] HP_MIN = {{(PW-31){1'b1}}, {31{1'b0}}};
  localparam logic [31:0] ROOT_TOP = 32'h4000_0000;
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // Configuration and window state
  logic [vzc_pkg::DUR_W-1:0] duration_ms;
  logic [RW-1:0]             sample_rate_hz;
  logic [CW-1:0]             sample_count;
  logic [AW-1:0]             previous_magnitude;
  logic signed [31:0]        highpass_value;
  logic [1:0]                last_sign;
  logic [CW-1:0]             sign_change_count;

  // Working registers
  logic signed [AW-1:0] ax, ay, az;
  logic [31:0]          acc, rem, root;
  logic signed [DW-1:0] dq;
  logic signed [PW-1:0] prod;
  logic [PRW-1:0]       win_prod, win_thresh;
  logic [NW-1:0]        num;
  logic [EW-1:0]        den;
  logic [HW-1:0]        limit;
  logic                 ovf;
  logic [EW-1:0]        drem;
  logic [QW-1:0]        quo;
  logic [HW-1:0]        out_hz;
  logic [CW-1:0]        out_count;
  logic                 out_clamped;

  // Combinational signals
  logic [RW-1:0]        rate_c;
  logic signed [AW-1:0] sq_in;
  logic signed [31:0]   sq_val;
  logic [31:0]          rem_in, root_in, root_bit, root_trial;
  logic signed [AW:0]   diff;
  logic signed [DW-1:0] dshift, dround;
  logic signed [SW-1:0] hp_sum;
  logic signed [PW-1:0] hp_round, hp_shift;
  logic signed [31:0]   hp_new;
  logic [1:0]           sign_now;
  logic [CW-1:0]        count_new, sc_new;
  logic [QW-1:0]        div_trial, div_sub;
  logic                 div_ge;
  logic                 over;
  logic [HW-1:0]        hz_final;

  assign rate_c = (sample_rate_hz < vzc_pkg::MIN_RATE) ? vzc_pkg::MIN_RATE : sample_rate_hz;

  // Shared squarer: one axis per step
  always_comb begin
    unique case (cmd.step[1:0])
      2'd0:    sq_in = ax;
      2'd1:    sq_in = ay;
      default: sq_in = az;
    endcase
    sq_val = sq_in * sq_in;
  end

  // One bit pair of the square root per step
  always_comb begin
    rem_in     = (cmd.step == '0) ? acc : rem;
    root_in    = (cmd.step == '0) ? 32'd0 : root;
    root_bit   = ROOT_TOP >> {cmd.step[3:0], 1'b0};
    root_trial = root_in + root_bit;
  end

  // Magnitude difference scaled to g, rounded half up
  always_comb begin
    diff   = $signed({1'b0, root[AW-1:0]}) - $signed({1'b0, previous_magnitude});
    dshift = DW'(diff) <<< HP_FRAC_BITS;
    dround = dshift + RND_D;
  end

  // Filter input sum, rounding and saturation of the new filter value
  always_comb begin
    hp_sum   = SW'(highpass_value) + SW'(dq);
    hp_round = prod + RND_A;
    hp_shift = hp_round >>> ALPHA_FRAC_BITS;
    priority if (hp_shift > HP_MAX) begin
      hp_new = 32'sh7FFF_FFFF;
    end else if (hp_shift < HP_MIN) begin
      hp_new = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      hp_new = hp_shift[31:0];
    end
    if (hp_new > 32'sd0) begin
      sign_now = SIGN_POS;
    end else if (hp_new < 32'sd0) begin
      sign_now = SIGN_NEG;
    end else begin
      sign_now = SIGN_NONE;
    end
    count_new = sign_change_count;
    if (last_sign != SIGN_NONE && sign_now != SIGN_NONE && sign_now != last_sign &&
        sign_change_count != '1) begin
      count_new = sign_change_count + 1'b1;
    end
    sc_new = (sample_count == '1) ? sample_count : sample_count + 1'b1;
  end

  // Restoring divider step and final clamp
  always_comb begin
    div_trial = {drem, quo[QW-1]};
    div_ge    = div_trial >= {1'b0, den};
    div_sub   = div_trial - {1'b0, den};
    over      = ovf || (quo > QW'(limit));
    hz_final  = over ? limit : quo[HW-1:0];
  end

  // Window ends once the sample count reaches duration * rate / 1000 or saturates
  assign status.window_done = (win_prod <= win_thresh) || (sample_count == '1);
  assign status.out_free    = !m_axis_tvalid || m_axis_tready;

  // Registers with reset: configuration, window state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms        <= vzc_pkg::DURATION_RESET;
      sample_rate_hz     <= vzc_pkg::RATE_RESET;
      sample_count       <= '0;
      previous_magnitude <= '0;
      highpass_value     <= '0;
      last_sign          <= SIGN_NONE;
      sign_change_count  <= '0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vzc_pkg::REG_DURATION: duration_ms    <= cfg_data;
          vzc_pkg::REG_RATE:     sample_rate_hz <= cfg_data[RW-1:0];
          default: ;
        endcase
      end
      // A result taken with no new one behind it empties the output register.
      if (m_axis_tvalid && m_axis_tready && cmd.op != vzc_pkg::OP_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (cmd.op)
        vzc_pkg::OP_DIFF: begin
          previous_magnitude <= root[AW-1:0];
        end
        vzc_pkg::OP_UPDATE: begin
          highpass_value    <= hp_new;
          sign_change_count <= count_new;
          sample_count      <= sc_new;
          if (sign_now != SIGN_NONE) begin
            last_sign <= sign_now;
          end
        end
        vzc_pkg::OP_EMIT: begin
          m_axis_tvalid      <= 1'b1;
          sample_count       <= '0;
          previous_magnitude <= '0;
          highpass_value     <= '0;
          last_sign          <= SIGN_NONE;
          sign_change_count  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      vzc_pkg::OP_LOAD: begin
        ax  <= s_axis_tdata[AW-1:0];
        ay  <= s_axis_tdata[2*AW-1:AW];
        az  <= s_axis_tdata[3*AW-1:2*AW];
        acc <= '0;
      end
      vzc_pkg::OP_MAC: begin
        acc <= acc + 32'(sq_val);
      end
      vzc_pkg::OP_ROOT: begin
        if (rem_in >= root_trial) begin
          rem  <= rem_in - root_trial;
          root <= (root_in >> 1) + root_bit;
        end else begin
          rem  <= rem_in;
          root <= root_in >> 1;
        end
      end
      vzc_pkg::OP_DIFF: begin
        dq <= dround >>> vzc_pkg::G_SHIFT;
      end
      vzc_pkg::OP_MUL: begin
        prod <= hp_sum * ALPHA_S;
      end
      vzc_pkg::OP_UPDATE: begin
        win_prod   <= PRW'(duration_ms) * PRW'(rate_c);
        win_thresh <= PRW'(sc_new) * PRW'(vzc_pkg::MS_PER_S) + PRW'(vzc_pkg::MS_PER_S - 1);
      end
      vzc_pkg::OP_DIVSET: begin
        limit <= {rate_c, {vzc_pkg::LIMIT_SHIFT{1'b0}}};
        if (duration_ms == '0) begin
          num <= NW'(sign_change_count) << vzc_pkg::LIMIT_SHIFT;
          den <= EW'(1);
        end else begin
          num <= NW'(sign_change_count) * NW'(vzc_pkg::HZ_SCALE) + NW'(duration_ms);
          den <= {duration_ms, 1'b0};
        end
      end
      vzc_pkg::OP_DIVCHK: begin
        // A quotient that needs more than QW bits is always above the limit.
        ovf  <= {1'b0, num} >= {den, {QW{1'b0}}};
        drem <= EW'(num[NW-1:QW]);
        quo  <= num[QW-1:0];
      end
      vzc_pkg::OP_DIV: begin
        drem <= div_ge ? div_sub[EW-1:0] : div_trial[EW-1:0];
        quo  <= {quo[QW-2:0], div_ge};
      end
      vzc_pkg::OP_EMIT: begin
        out_hz      <= hz_final;
        out_count   <= sign_change_count;
        out_clamped <= over;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {{(vzc_pkg::OUT_TDATA_W - HW - CW){1'b0}}, out_count, out_hz};
  assign m_axis_tuser = out_clamped;

endmodule

[rtl/vibration_zero_crossing_freq.sv]
// Zero-crossing vibration frequency estimator, top level.
// An item passes from acceptance through the shared squarer, the bit-pair square root,
// the filter and the window check before the next can be accepted.
// The item that closes a window then runs the 18-step divider, and its result may wait
// for the output register to be free.
// Reset (rst, synchronous) restores the register defaults and clears window state.
module vibration_zero_crossing_freq #(
  parameter int HP_FRAC_BITS    = vzc_pkg::HP_FRAC_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = vzc_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [vzc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // vibration_hz_q8 [16:0], crossing_count [32:17], zero fill [39:33]
  output logic [vzc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // was_clamped [0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [vzc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vzc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vzc_pkg::cmd_t    cmd;
  vzc_pkg::status_t status;

  // Sequencer
  vzc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Arithmetic and state
  vzc_datapath #(
    .HP_FRAC_BITS    (HP_FRAC_BITS),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

[rtl/vzc_checker.sv]
// Port-level checks for the estimator top level and the bind that
// attaches them. Depends on vzc_pkg and vibration_zero_crossing_freq.
module vzc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [vzc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One item at a time: no acceptance in the cycle after one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A clamped estimate is rate * 128 with rate at least 20.
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[6:0] == 7'd0 && m_axis_tdata[16:0] >= 17'd2560)
    else $error("clamped estimate is not a valid limit");

  // No crossings means a zero estimate, never clamped.
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32:17] == 16'd0 |->
      m_axis_tdata[16:0] == 17'd0 && !m_axis_tuser)
    else $error("nonzero estimate without crossings");

  // After reset the block is empty and ready.
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind vibration_zero_crossing_freq vzc_checker u_vzc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
